@@ rtl/core/signed_integer_to_radix_symbols_defines.svh @@
// Assertion macros for the radix symbol renderer.
// Each macro checks one implication on the rising edge of the given clock,
// and is disabled while the given active-low reset is asserted.
`ifndef SIGNED_INTEGER_TO_RADIX_SYMBOLS_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_SYMBOLS_DEFINES_SVH
`ifndef SYNTHESIS
`define SIRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sirs: same-cycle check failed");
`define SIRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sirs: next-cycle check failed");
`else
`define SIRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SIRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/sirs_pkg.sv @@
package sirs_pkg;

  localparam int unsigned NUM_W      = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BASE_W     = 5;
  localparam int unsigned MAX_DIGITS = 32;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned CNT_W      = 6;

  localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] SYM_LOW   = 8'd32;
  localparam logic [CHAR_W-1:0] SYM_HIGH  = 8'd126;

  typedef struct packed {
    logic [BASE_W-1:0] base_size;
    logic [63:0]       symbols_high;
    logic [63:0]       symbols_low;
  } cfg_t;

  // One classified number waiting for the back end.
  typedef struct packed {
    logic             invalid;
    logic             neg;
    logic [NUM_W-1:0] mag;
  } job_t;

  function automatic logic [CHAR_W-1:0] symbol_at(cfg_t cfg, logic [DIGIT_W-1:0] idx);
    logic [127:0] all;
    all = {cfg.symbols_high, cfg.symbols_low};
    return all[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

@@ rtl/core/sirs_if.sv @@
interface sirs_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sirs_pkg::NUM_W-1:0] number;
  modport source (output valid, number, input ready);
  modport sink (input valid, number, output ready);
endinterface

interface sirs_out_if;
  logic                        valid;
  logic                        ready;
  logic [sirs_pkg::CHAR_W-1:0] character;
  logic                        last;
  logic                        base_invalid;
  modport source (output valid, character, last, base_invalid, input ready);
  modport sink (input valid, character, last, base_invalid, output ready);
endinterface

@@ rtl/core/sirs_front.sv @@
module sirs_front #(
  parameter int MAX_SYMBOLS = 16
) (
  sirs_in_if.sink          in_ch,
  input  sirs_pkg::cfg_t   cfg,
  output logic             push,
  output sirs_pkg::job_t   push_job,
  input  logic             full
);

  logic                         base_ok;
  logic [sirs_pkg::CHAR_W-1:0]  c;
  logic [sirs_pkg::NUM_W-1:0]   raw;

  // Check the symbol set against the current registers.
  always_comb begin
    base_ok = (cfg.base_size >= 5'd2) &&
              (cfg.base_size <= sirs_pkg::BASE_W'(MAX_SYMBOLS));
    c = '0;
    for (int a = 0; a < MAX_SYMBOLS; a++) begin
      if (a < cfg.base_size) begin
        c = sirs_pkg::symbol_at(cfg, sirs_pkg::DIGIT_W'(a));
        if (c == sirs_pkg::SYM_PLUS || c == sirs_pkg::SYM_MINUS ||
            c < sirs_pkg::SYM_LOW || c > sirs_pkg::SYM_HIGH) begin
          base_ok = 1'b0;
        end
        for (int b = a + 1; b < MAX_SYMBOLS; b++) begin
          if (b < cfg.base_size &&
              sirs_pkg::symbol_at(cfg, sirs_pkg::DIGIT_W'(b)) == c) begin
            base_ok = 1'b0;
          end
        end
      end
    end
  end

  assign raw              = in_ch.number;
  assign in_ch.ready      = !full;
  assign push             = in_ch.valid && !full;
  assign push_job.invalid = !base_ok;
  assign push_job.neg     = raw[sirs_pkg::NUM_W-1];
  assign push_job.mag     = raw[sirs_pkg::NUM_W-1] ? (~raw + 32'd1) : raw;

endmodule

@@ rtl/core/sirs_fifo.sv @@
module sirs_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sirs_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output sirs_pkg::job_t pop_job,
  output logic           empty
);

  localparam int unsigned DEPTH = 2;

  sirs_pkg::job_t q_r [DEPTH];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'(DEPTH));
  assign empty   = (cnt_r == 2'd0);
  assign pop_job = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/core/sirs_back.sv @@
module sirs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  sirs_pkg::cfg_t cfg,
  input  logic           empty,
  input  sirs_pkg::job_t pop_job,
  output logic           pop,
  sirs_out_if.source     out_ch
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_SIGN = 6'b000100,
    ST_RD   = 6'b001000,
    ST_LOAD = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [sirs_pkg::NUM_W-1:0]    mag_r, mag_nxt;
  logic [sirs_pkg::DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [1:0]                    step_r, step_nxt;
  logic                          neg_r, neg_nxt;
  logic [sirs_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [sirs_pkg::CHAR_W-1:0]   char_r, char_nxt;
  logic                          last_r, last_nxt;
  logic                          inv_r, inv_nxt;

  logic [sirs_pkg::DIGIT_W-1:0]  mem_r [sirs_pkg::MAX_DIGITS];
  logic [sirs_pkg::DIGIT_W-1:0]  rdata_r;
  logic                          mem_we, mem_re;
  logic [sirs_pkg::ADDR_W-1:0]   rd_addr;

  logic [sirs_pkg::DIGIT_W-1:0]  div_r;
  logic [sirs_pkg::DIGIT_W:0]    div_acc;
  logic [7:0]                    div_q;
  logic [sirs_pkg::DIGIT_W-1:0]  div_rem;
  logic [sirs_pkg::NUM_W-1:0]    div_quo;

  // Eight restoring steps: feed the top byte of the dividend through the remainder.
  always_comb begin
    div_r   = rem_r;
    div_acc = '0;
    div_q   = '0;
    for (int i = 7; i >= 0; i--) begin
      div_acc = {div_r, mag_r[24+i]};
      if (div_acc >= cfg.base_size) begin
        div_acc  = div_acc - cfg.base_size;
        div_q[i] = 1'b1;
      end
      div_r = div_acc[sirs_pkg::DIGIT_W-1:0];
    end
    div_rem = div_r;
    div_quo = {mag_r[23:0], div_q};
  end

  assign rd_addr = sirs_pkg::ADDR_W'(cnt_r - 6'd1);

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    inv_nxt   = inv_r;
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (pop_job.invalid) begin
            char_nxt  = '0;
            last_nxt  = 1'b1;
            inv_nxt   = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            mag_nxt   = pop_job.mag;
            neg_nxt   = pop_job.neg;
            rem_nxt   = '0;
            step_nxt  = '0;
            cnt_nxt   = '0;
            inv_nxt   = 1'b0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        mag_nxt  = div_quo;
        rem_nxt  = div_rem;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          // Digit finished: store remainder, restart on the quotient.
          mem_we  = 1'b1;
          rem_nxt = '0;
          cnt_nxt = cnt_r + 6'd1;
          if (div_quo == '0 || cnt_r == 6'(sirs_pkg::MAX_DIGITS - 1)) begin
            state_nxt = ST_SIGN;
          end
        end
      end
      ST_SIGN: begin
        if (neg_r) begin
          char_nxt  = sirs_pkg::SYM_MINUS;
          last_nxt  = 1'b0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        char_nxt  = sirs_pkg::symbol_at(cfg, rdata_r);
        last_nxt  = (cnt_r == 6'd1);
        cnt_nxt   = cnt_r - 6'd1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = last_r ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    inv_r  <= inv_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[cnt_r[sirs_pkg::ADDR_W-1:0]] <= div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  assign out_ch.valid        = (state_r == ST_OUT);
  assign out_ch.character    = char_r;
  assign out_ch.last         = last_r;
  assign out_ch.base_invalid = inv_r;

endmodule

@@ rtl/core/signed_integer_to_radix_symbols.sv @@
// Channel | Direction | Beat payload                      | Handshake
// in_ch   | sink      | number (32-bit signed)            | valid / ready
// out_ch  | source    | character (8), last, base_invalid | valid / ready
// cfg     | APB slave | base_size, symbols_low/high @ 8*i | psel/penable, pready = 1
//
// Per number: a pop from the queue, the divider working out each digit (8
// restoring steps per cycle), a sign decision (plus a '-' beat for a negative
// number), then per digit beat a digit store read, a symbol lookup and the
// output beat. An out_ch stall holds the current beat until it is taken.
// An invalid symbol set yields one status beat.
// Reset (rst_n low, synchronous) clears registers, queue and sequencer.
// The front end takes a new number while the back end stalls on out_ch, until
// its two-entry queue fills.
`include "signed_integer_to_radix_symbols_defines.svh"

module signed_integer_to_radix_symbols #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sirs_in_if.sink     in_ch,
  sirs_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_BASE_SIZE    = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  logic [sirs_pkg::BASE_W-1:0] base_size_r;
  logic [63:0]                 symbols_low_r;
  logic [63:0]                 symbols_high_r;
  logic                        cfg_wr;
  sirs_pkg::cfg_t              cfg;

  logic                        q_push;
  sirs_pkg::job_t              q_push_job;
  logic                        q_full;
  logic                        q_pop;
  sirs_pkg::job_t              q_pop_job;
  logic                        q_empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Config writes: unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r    <= '0;
      symbols_low_r  <= '0;
      symbols_high_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_BASE_SIZE:    base_size_r    <= pwdata[sirs_pkg::BASE_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low_r  <= pwdata;
        REG_SYMBOLS_HIGH: symbols_high_r <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_BASE_SIZE:    prdata = {59'd0, base_size_r};
      REG_SYMBOLS_LOW:  prdata = symbols_low_r;
      REG_SYMBOLS_HIGH: prdata = symbols_high_r;
      default:          prdata = '0;
    endcase
  end

  assign cfg.base_size    = base_size_r;
  assign cfg.symbols_low  = symbols_low_r;
  assign cfg.symbols_high = symbols_high_r;

  // Front end: validate the symbol set, form sign and magnitude, enqueue.
  sirs_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_front (
    .in_ch    (in_ch),
    .cfg      (cfg),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full)
  );

  sirs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .empty    (q_empty)
  );

  // Back end: divide into the digit store, then emit sign and symbols.
  sirs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .empty   (q_empty),
    .pop_job (q_pop_job),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  // A status beat is always a single, zero-character, final beat.
  `SIRS_ASSERT_NOW(a_status_form, clk, rst_n, out_ch.valid && out_ch.base_invalid, out_ch.last && out_ch.character == 8'd0)
  // The sign never ends a text: digits follow it.
  `SIRS_ASSERT_NOW(a_sign_not_last, clk, rst_n, out_ch.valid && !out_ch.base_invalid && out_ch.character == sirs_pkg::SYM_MINUS, !out_ch.last)
  // An accepted number is held in the queue on the next cycle.
  `SIRS_ASSERT_NEXT(a_queue_holds, clk, rst_n, in_ch.valid && in_ch.ready, !q_empty)

endmodule

@@ tb/tb_signed_integer_to_radix_symbols.sv @@
`timescale 1ns / 100ps

module tb_signed_integer_to_radix_symbols;

  localparam int unsigned NUM_W      = sirs_pkg::NUM_W;
  localparam int unsigned CHAR_W     = sirs_pkg::CHAR_W;
  localparam int unsigned DIGIT_W    = sirs_pkg::DIGIT_W;
  localparam int unsigned BASE_W     = sirs_pkg::BASE_W;
  localparam int unsigned MAX_DIGITS = sirs_pkg::MAX_DIGITS;
  localparam logic [CHAR_W-1:0] SYM_PLUS  = sirs_pkg::SYM_PLUS;
  localparam logic [CHAR_W-1:0] SYM_MINUS = sirs_pkg::SYM_MINUS;
  localparam logic [CHAR_W-1:0] SYM_LOW   = sirs_pkg::SYM_LOW;
  localparam logic [CHAR_W-1:0] SYM_HIGH  = sirs_pkg::SYM_HIGH;

  localparam int SYMBOL_LIMIT  = 16;
  localparam int RANDOM_ITEMS  = 386;
  // The last stretch of random items runs with no idling on either side.
  localparam int QUIET_ITEMS   = 80;
  localparam int MAX_SHOWN     = 10;
  // Worst number: 32 digits through the divider plus 33 text beats.
  localparam int SETTLE_CYCLES = 300;

  // Register map: one 64-bit register every eight bytes.
  typedef enum logic [4:0] {
    REG_BASE_SIZE    = 5'd0,
    REG_SYMBOLS_LOW  = 5'd8,
    REG_SYMBOLS_HIGH = 5'd16
  } cfg_addr_t;

  // Ways to spoil a symbol set while keeping the radix in range.
  typedef enum int {
    FAULT_NONE,
    FAULT_PLUS,
    FAULT_MINUS,
    FAULT_CONTROL,
    FAULT_HIGH,
    FAULT_REPEAT
  } set_fault_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              base_invalid;
  } text_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  sirs_in_if  in_if ();
  sirs_out_if out_if ();

  signed_integer_to_radix_symbols #(
    .MAX_SYMBOLS(SYMBOL_LIMIT)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Shadow of the configuration registers, updated at the APB write edge.
  logic [BASE_W-1:0] radix_q;
  logic [63:0]       sym_low_q;
  logic [63:0]       sym_high_q;

  // Text beats predicted for accepted numbers, oldest first.
  text_beat_t pending_text[$];

  // Gaps on the number side and stalls on the text side follow this flag.
  bit idles_on = 1'b1;

  int numbers_sent;
  int beats_checked;
  int status_beats;
  int sets_loaded;
  int failures;

  function automatic void note_failure(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
    failures++;
    if (failures <= MAX_SHOWN)
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
  endfunction

  // Symbol byte for a digit value, taken from the shadow registers.
  function automatic logic [CHAR_W-1:0] symbol_of(input logic [DIGIT_W-1:0] idx);
    logic [127:0] both;
    both = {sym_high_q, sym_low_q};
    return CHAR_W'(both >> (32'(idx) * 8));
  endfunction

  // The set is usable when the radix is in range and every symbol in use is
  // printable, not a sign, and unique.
  function automatic bit symbol_set_ok();
    int n;
    logic [CHAR_W-1:0] c;
    n = int'(radix_q);
    if (n < 2 || n > SYMBOL_LIMIT) return 1'b0;
    for (int a = 0; a < n; a++) begin
      c = symbol_of(DIGIT_W'(a));
      if (c == SYM_PLUS || c == SYM_MINUS || c < SYM_LOW || c > SYM_HIGH) return 1'b0;
      for (int b = a + 1; b < n; b++)
        if (symbol_of(DIGIT_W'(b)) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the text of one number: a single status beat for a bad set, else
  // an optional sign and the digits most significant first.
  function automatic void predict_text(input logic [NUM_W-1:0] value);
    logic [NUM_W-1:0]   mag;
    logic [NUM_W-1:0]   radix;
    logic [DIGIT_W-1:0] digits [MAX_DIGITS];
    int n;
    if (!symbol_set_ok()) begin
      pending_text.push_back('{'0, 1'b1, 1'b1});
      return;
    end
    radix = NUM_W'(radix_q);
    // Negate as unsigned so the most negative number keeps its magnitude.
    mag = value[NUM_W-1] ? -value : value;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % radix);
      mag = mag / radix;
      n++;
    end while (mag != 0 && n < MAX_DIGITS);
    if (value[NUM_W-1]) pending_text.push_back('{SYM_MINUS, 1'b0, 1'b0});
    for (int i = n - 1; i >= 0; i--)
      pending_text.push_back('{symbol_of(digits[i]), i == 0, 1'b0});
  endfunction

  // Build n distinct printable symbols, then spoil one if asked. Bytes past
  // the radix stay random, since the block must ignore them.
  function automatic logic [127:0] make_symbol_set(input int n, input set_fault_t fault);
    logic [127:0]      packed_set;
    logic [CHAR_W-1:0] c;
    bit                taken [256];
    int                pos;
    int                other;
    packed_set = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < n && i < SYMBOL_LIMIT; i++) begin
      do c = CHAR_W'($urandom_range(SYM_LOW, SYM_HIGH));
      while (c == SYM_PLUS || c == SYM_MINUS || taken[c]);
      taken[c] = 1'b1;
      packed_set[i*8 +: 8] = c;
    end
    if (fault != FAULT_NONE) begin
      pos = $urandom_range(0, n - 1);
      case (fault)
        FAULT_PLUS:    packed_set[pos*8 +: 8] = SYM_PLUS;
        FAULT_MINUS:   packed_set[pos*8 +: 8] = SYM_MINUS;
        FAULT_CONTROL: packed_set[pos*8 +: 8] = CHAR_W'($urandom_range(0, SYM_LOW - 1));
        FAULT_HIGH:    packed_set[pos*8 +: 8] = CHAR_W'($urandom_range(SYM_HIGH + 1, 255));
        FAULT_REPEAT: begin
          other = (pos + $urandom_range(1, n - 1)) % n;
          packed_set[pos*8 +: 8] = packed_set[other*8 +: 8];
        end
        default: ;
      endcase
    end
    return packed_set;
  endfunction

  // Mostly full-width values, with small values, extremes and short
  // magnitudes mixed in so that every digit count shows up.
  function automatic logic [NUM_W-1:0] random_number();
    logic [NUM_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      3: v = NUM_W'(int'($urandom_range(0, 600)) - 300);
      4: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = '0;
          3:       v = '1;
          default: v = 32'h8000_0001;
        endcase
      end
      5: begin
        v = $urandom >> $urandom_range(1, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: ;
    endcase
    return v;
  endfunction

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic write, input cfg_addr_t addr,
                            input logic [63:0] wdata, output logic [63:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (write) begin
      case (addr)
        REG_BASE_SIZE:    radix_q    = wdata[BASE_W-1:0];
        REG_SYMBOLS_LOW:  sym_low_q  = wdata;
        REG_SYMBOLS_HIGH: sym_high_q = wdata;
        default: ;
      endcase
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input cfg_addr_t addr, input logic [63:0] want);
    logic [63:0] got;
    apb_access(1'b0, addr, '0, got);
    if (got !== want) note_failure($sformatf("register 0x%0h readback", addr), want, got);
  endtask

  // Write radix and symbols (junk above the radix field), then read all back.
  task automatic load_symbol_set(input logic [BASE_W-1:0] radix, input logic [127:0] symbols);
    logic [63:0] unused;
    apb_access(1'b1, REG_BASE_SIZE, {$urandom, 27'($urandom), radix}, unused);
    apb_access(1'b1, REG_SYMBOLS_LOW, symbols[63:0], unused);
    apb_access(1'b1, REG_SYMBOLS_HIGH, symbols[127:64], unused);
    check_register(REG_BASE_SIZE, 64'(radix));
    check_register(REG_SYMBOLS_LOW, symbols[63:0]);
    check_register(REG_SYMBOLS_HIGH, symbols[127:64]);
    sets_loaded++;
  endtask

  // Present one number and hold it until accepted. Returns at a falling edge
  // with valid still high so the next beat can follow back to back.
  task automatic send_number(input logic [NUM_W-1:0] value);
    if (idles_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.number <= value;
    do @(posedge clk); while (!in_if.ready);
    predict_text(value);
    numbers_sent++;
    @(negedge clk);
  endtask

  task automatic release_input();
    in_if.valid <= 1'b0;
  endtask

  // Hold until every predicted beat has come out.
  task automatic wait_for_text();
    while (pending_text.size() != 0) @(negedge clk);
  endtask

  // Registers come out of reset at zero, so the radix is 0 and any number
  // draws the status beat.
  task automatic test_reset_status();
    check_register(REG_BASE_SIZE, '0);
    check_register(REG_SYMBOLS_LOW, '0);
    check_register(REG_SYMBOLS_HIGH, '0);
    send_number(32'd12345);
    release_input();
    wait_for_text();
  endtask

  // Plain decimal digits: zero, single digits, signs, both extremes.
  task automatic test_decimal_text();
    logic [NUM_W-1:0] values [8];
    values = '{32'd0, 32'd7, -32'd7, 32'd10, '1, 32'h7fff_ffff, 32'h8000_0000,
               32'd1_000_000_000};
    load_symbol_set(BASE_W'(10),
                    {$urandom, 16'($urandom), 8'h39, 8'h38, 64'h3736_3534_3332_3130});
    foreach (values[i]) send_number(values[i]);
    release_input();
    wait_for_text();
  endtask

  // Radix 2 gives the longest text (sign plus 32 digits); radix 16 uses the
  // printable limits, space and tilde, as symbols.
  task automatic test_radix_extremes();
    load_symbol_set(BASE_W'(2), {$urandom, $urandom, $urandom, 16'($urandom), 8'h31, 8'h30});
    send_number(32'h8000_0000);
    send_number(32'h7fff_ffff);
    send_number('1);
    send_number('0);
    release_input();
    wait_for_text();
    load_symbol_set(BASE_W'(SYMBOL_LIMIT),
                    {64'h4E4D_4C4B_4A49_4847, 64'h4645_4443_4241_7E20});
    send_number(32'h7fff_ffff);
    send_number(32'h8000_0000);
    send_number(32'h0000_000f);
    release_input();
    wait_for_text();
  endtask

  // One number per way a symbol set can be rejected.
  task automatic test_invalid_symbol_sets();
    int bad_radix [3];
    int n;
    bad_radix = '{1, SYMBOL_LIMIT + 1, 31};
    foreach (bad_radix[i]) begin
      load_symbol_set(BASE_W'(bad_radix[i]), make_symbol_set(bad_radix[i], FAULT_NONE));
      send_number(random_number());
      release_input();
      wait_for_text();
    end
    for (int f = FAULT_PLUS; f <= FAULT_REPEAT; f++) begin
      n = $urandom_range(2, SYMBOL_LIMIT);
      load_symbol_set(BASE_W'(n), make_symbol_set(n, set_fault_t'(f)));
      send_number(random_number());
      release_input();
      wait_for_text();
    end
  endtask

  // Pick a set for the next phase: mostly valid, radix extremes favored,
  // with the occasional spoiled set or out-of-range radix.
  task automatic load_random_set();
    int n;
    set_fault_t fault;
    fault = FAULT_NONE;
    case ($urandom_range(0, 11))
      0: n = 2;
      1: n = SYMBOL_LIMIT;
      2: n = 10;
      3: begin
        n = $urandom_range(2, SYMBOL_LIMIT);
        fault = set_fault_t'($urandom_range(FAULT_PLUS, FAULT_REPEAT));
      end
      4: n = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1)
                                         : $urandom_range(SYMBOL_LIMIT + 1, 31);
      default: n = $urandom_range(2, SYMBOL_LIMIT);
    endcase
    load_symbol_set(BASE_W'(n), make_symbol_set(n, fault));
  endtask

  // Phases of random numbers, each under a fresh symbol set. The registers
  // change only once the previous phase has drained.
  task automatic test_random_text();
    int sent;
    int phase;
    int burst;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      load_random_set();
      idles_on = (sent < RANDOM_ITEMS - QUIET_ITEMS) ? ($urandom_range(0, 3) != 0) : 1'b0;
      burst = $urandom_range(20, 40);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        if (sent >= RANDOM_ITEMS - QUIET_ITEMS) idles_on = 1'b0;
        send_number(random_number());
        sent++;
        // Once, stop mid-phase and drain everything before going on.
        if (phase == 3 && i == burst / 2) begin
          release_input();
          wait_for_text();
        end
      end
      release_input();
      wait_for_text();
      phase++;
    end
  endtask

  // Text-side ready: random stall bursts while idling is on.
  initial begin : drive_text_ready
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (idles_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 11) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted text beat with the oldest prediction.
  always @(posedge clk) begin : check_text
    text_beat_t got;
    text_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.character, out_if.last, out_if.base_invalid};
      beats_checked++;
      if (got.base_invalid) status_beats++;
      if (pending_text.size() == 0) begin
        note_failure("text beat with nothing pending", '0, 64'(got));
      end else begin
        want = pending_text.pop_front();
        if (got.character !== want.character)
          note_failure("character", 64'(want.character), 64'(got.character));
        if (got.last !== want.last)
          note_failure("last", 64'(want.last), 64'(got.last));
        if (got.base_invalid !== want.base_invalid)
          note_failure("base_invalid", 64'(want.base_invalid), 64'(got.base_invalid));
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.number = '0;
    radix_q      = '0;
    sym_low_q    = '0;
    sym_high_q   = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_status();
    test_decimal_text();
    test_radix_extremes();
    test_invalid_symbol_sets();
    test_random_text();

    // Drain, then give the block time to show any stray beat.
    release_input();
    wait_for_text();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Rendered %0d numbers as %0d text beats under %0d symbol set loads;",
             numbers_sent, beats_checked, sets_loaded);
    $display("%0d beats were rejected-set status, %0d failures seen.", status_beats, failures);
    if (failures == 0) begin
      $display("tb_signed_integer_to_radix_symbols passed");
    end else begin
      $display("tb_signed_integer_to_radix_symbols failed");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #10ms;
    $display("tb_signed_integer_to_radix_symbols failed");
    $finish;
  end

endmodule

@@ signed_integer_to_radix_symbols.f @@
+incdir+rtl/core
rtl/core/sirs_pkg.sv
rtl/core/sirs_if.sv
rtl/core/sirs_front.sv
rtl/core/sirs_fifo.sv
rtl/core/sirs_back.sv
rtl/core/signed_integer_to_radix_symbols.sv
tb/tb_signed_integer_to_radix_symbols.sv
